// File: hdl/ctrd_pkg.sv
// ctrd_pkg: shared types and codes for the coverage threshold region detector
// event command codes, region kinds, register indexes and the region result word
// no dependencies

package ctrd_pkg;

    // event commands; code 3 carries no meaning and is ignored
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_END    = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    // register indexes on the configuration channel
    localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_CONTIG_LENGTH  = 2'd2;

    // region kinds
    localparam logic KIND_LOW  = 1'b0;
    localparam logic KIND_HIGH = 1'b1;

    // reset values of the registers
    localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd1;
    localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd100;
    localparam logic [30:0] CONTIG_LENGTH_RESET  = 31'd0;

    // width of contig positions on the ports
    localparam int OUT_POS_BITS = 31;

    // one reported region, plus a flag that says it exists
    typedef struct packed {
        logic                    found;
        logic                    kind;
        logic [OUT_POS_BITS-1:0] start_pos;
        logic [OUT_POS_BITS-1:0] end_pos;
    } region_t;

endpackage

// File: hdl/ctrd_update.sv
// ctrd_update: per-event update of coverage count and open region start
// clamps the position, steps the count and decides whether a region closes
// depends on ctrd_pkg

module ctrd_update #(
    parameter int COUNT_BITS = 16,
    parameter int POS_BITS   = 31
) (
    input  logic [1:0]                cmd,
    input  logic signed [31:0]        position,
    input  logic [15:0]               low_threshold,
    input  logic [15:0]               high_threshold,
    input  logic [30:0]               contig_length,
    input  logic [COUNT_BITS-1:0]     count,
    input  logic [POS_BITS-1:0]       open_start,
    output logic [COUNT_BITS-1:0]     count_next,
    output logic [POS_BITS-1:0]       open_start_next,
    output ctrd_pkg::region_t         region
);
    import ctrd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int WIDE  = (POS_BITS > OUT_POS_BITS) ? POS_BITS : OUT_POS_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // port position to internal position width
    function automatic logic [POS_BITS-1:0] to_pos(input logic [OUT_POS_BITS-1:0] v);
        logic [WIDE-1:0] w;
        w = WIDE'(v);
        return w[POS_BITS-1:0];
    endfunction

    // internal position to port position width
    function automatic logic [OUT_POS_BITS-1:0] to_out(input logic [POS_BITS-1:0] v);
        logic [WIDE-1:0] w;
        w = WIDE'(v);
        return w[OUT_POS_BITS-1:0];
    endfunction

    logic [30:0]           clamped;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   len;
    logic [CMP_W-1:0]      low_w;
    logic [CMP_W-1:0]      high_w;
    logic [CMP_W-1:0]      count_w;
    logic [COUNT_BITS-1:0] count_mid;
    logic [POS_BITS-1:0]   start_mid;

    // clamp position to 0..contig_length
    always_comb
    begin
        if (position[31])
            clamped = '0;
        else if (position[30:0] > contig_length)
            clamped = contig_length;
        else
            clamped = position[30:0];
    end

    assign pos     = to_pos(clamped);
    assign len     = to_pos(contig_length);
    assign low_w   = CMP_W'(low_threshold);
    assign high_w  = CMP_W'(high_threshold);
    assign count_w = CMP_W'(count);

    // count step, region close and start update
    always_comb
    begin
        count_next      = count;
        open_start_next = open_start;
        region          = '0;
        count_mid       = count;
        start_mid       = open_start;
        case (cmd)
            CMD_START:
            begin
                if (count != COUNT_MAX)
                begin
                    start_mid       = (count_w == high_w) ? pos : open_start;
                    count_mid       = count + COUNT_BITS'(1);
                    count_next      = count_mid;
                    open_start_next = start_mid;
                    if (CMP_W'(count_mid) == low_w)
                    begin
                        if (pos > start_mid)
                        begin
                            region.found     = 1'b1;
                            region.kind      = KIND_LOW;
                            region.start_pos = to_out(start_mid);
                            region.end_pos   = to_out(pos);
                        end
                        open_start_next = pos;
                    end
                end
            end
            CMD_END:
            begin
                if (count != '0)
                begin
                    start_mid       = (count_w == low_w) ? pos : open_start;
                    count_mid       = count - COUNT_BITS'(1);
                    count_next      = count_mid;
                    open_start_next = start_mid;
                    if (CMP_W'(count_mid) == high_w)
                    begin
                        if (pos > start_mid)
                        begin
                            region.found     = 1'b1;
                            region.kind      = KIND_HIGH;
                            region.start_pos = to_out(start_mid);
                            region.end_pos   = to_out(pos);
                        end
                        open_start_next = pos;
                    end
                end
            end
            CMD_FINISH:
            begin
                // trailing low region up to the contig end, then clear
                if (len > open_start)
                begin
                    region.found     = 1'b1;
                    region.kind      = KIND_LOW;
                    region.start_pos = to_out(open_start);
                    region.end_pos   = to_out(len);
                end
                count_next      = '0;
                open_start_next = '0;
            end
            default:
            begin
                count_next      = count;
                open_start_next = open_start;
            end
        endcase
    end

endmodule

// File: hdl/coverage_threshold_region_detector_unit.sv
// coverage_threshold_region_detector_unit: top level of the region detector
// event input register, update logic, region result register, config registers
// depends on ctrd_pkg and ctrd_update
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  event    | event_valid, event_stall | cmd, position
//  region   | region_valid, region_stall | region_kind, region_start, region_end
//  config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// one event per cycle while event_stall is low; an event enters the event register at
// the edge that takes it and its region word is then loaded into the result register,
// set by the single update stage between the two registers
// reset restores thresholds 1 and 100, contig length 0, coverage 0, region start 0
// event_stall rises only while the event register holds a word and a stalled
// region word blocks the result register; cfg_ready is always high

module coverage_threshold_region_detector_unit #(
    parameter int COUNT_BITS = 16,
    parameter int POS_BITS   = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               event_valid,
    output logic               event_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] position,
    output logic               region_valid,
    input  logic               region_stall,
    output logic               region_kind,
    output logic [30:0]        region_start,
    output logic [30:0]        region_end,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import ctrd_pkg::*;

    logic                  ev_valid_reg;
    logic [1:0]            cmd_reg;
    logic signed [31:0]    pos_reg;
    logic [15:0]           low_reg;
    logic [15:0]           high_reg;
    logic [30:0]           length_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [POS_BITS-1:0]   open_start_reg;
    logic [POS_BITS-1:0]   open_start_next;
    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [30:0]           start_reg;
    logic [30:0]           end_reg;
    region_t               region;
    logic                  advance;

    // event register moves on when the result register is free or draining
    assign advance     = ev_valid_reg && (!out_valid_reg || !region_stall);
    assign event_stall = ev_valid_reg && !advance;
    assign cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= LOW_THRESHOLD_RESET;
            high_reg   <= HIGH_THRESHOLD_RESET;
            length_reg <= CONTIG_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_THRESHOLD:  low_reg    <= cfg_data[15:0];
                CFG_HIGH_THRESHOLD: high_reg   <= cfg_data[15:0];
                CFG_CONTIG_LENGTH:  length_reg <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    // event input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (!event_stall)
            ev_valid_reg <= event_valid;
    end

    always_ff @(posedge clk)
    begin
        if (event_valid && !event_stall)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
        end
    end

    // per-event update
    ctrd_update #(
        .COUNT_BITS (COUNT_BITS),
        .POS_BITS   (POS_BITS)
    ) u_update (
        .cmd             (cmd_reg),
        .position        (pos_reg),
        .low_threshold   (low_reg),
        .high_threshold  (high_reg),
        .contig_length   (length_reg),
        .count           (count_reg),
        .open_start      (open_start_reg),
        .count_next      (count_next),
        .open_start_next (open_start_next),
        .region          (region)
    );

    // coverage state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            open_start_reg <= '0;
        end
        else if (advance)
        begin
            count_reg      <= count_next;
            open_start_reg <= open_start_next;
        end
    end

    // region result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= region.found;
        else if (!region_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && region.found)
        begin
            kind_reg  <= region.kind;
            start_reg <= region.start_pos;
            end_reg   <= region.end_pos;
        end
    end

    assign region_valid = out_valid_reg;
    assign region_kind  = kind_reg;
    assign region_start = start_reg;
    assign region_end   = end_reg;

    // a finish event leaves the coverage state cleared
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_FINISH) |=> (count_reg == '0 && open_start_reg == '0))
        else $error("coverage state not cleared after finish");

    // coverage state holds while no event is processed
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(open_start_reg)))
        else $error("coverage state changed without an event");

    // reported regions are never empty
    a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        region_valid |-> (region_end > region_start))
        else $error("empty region reported");

    // a pending region cannot be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (region_valid && region_stall) |-> !advance)
        else $error("result register overrun");

endmodule
